// ----- sv/rdc_pkg.sv -----
// Shared types, constants and helpers for the radix digit converter.
package rdc_pkg;

   // Field widths fixed by the beat format
   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   // Radix limits and reset value
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   // ASCII mapping constants
   localparam logic [CHAR_W-1:0]  ASCII_ZERO        = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  ASCII_LETTER_BIAS = CHAR_W'(55);
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT     = DIGIT_W'(10);

   // Sequencer states of the top level
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SHOW
   } rdc_state_type;

   // Clamp a raw radix register into the supported range
   function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] raw);
      logic [RADIX_W-1:0] r;
      begin
         if (raw < RADIX_MIN) begin
            r = RADIX_MIN;
         end else if (raw > RADIX_MAX) begin
            r = RADIX_MAX;
         end else begin
            r = raw;
         end
         return r;
      end
   endfunction

   // Map a digit value onto '0'..'9' or 'A'..'Z'
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      begin
         if (d < DECIMAL_LIMIT) begin
            c = CHAR_W'(d) + ASCII_ZERO;
         end else begin
            c = CHAR_W'(d) + ASCII_LETTER_BIAS;
         end
         return c;
      end
   endfunction

endpackage

// ----- sv/rdc_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface rdc_req_if #(parameter int VALUE_BITS = 20);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdc_rsp_if;
   import rdc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- sv/rdc_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle by a small divisor.
module rdc_divider #(
   parameter int VALUE_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [VALUE_BITS-1:0]         dividend,
   input  logic [rdc_pkg::RADIX_W-1:0]   divisor,
   output logic                          done,
   output logic [VALUE_BITS-1:0]         quotient,
   output logic [rdc_pkg::DIGIT_W-1:0]   remainder
);
   import rdc_pkg::*;

   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    div_ff, div_in;

   logic [DIGIT_W:0]      trial;
   logic [DIGIT_W:0]      diff;
   logic                  fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_BITS-1]};
      fits  = (trial >= {1'b0, div_ff});
      diff  = trial - {1'b0, div_ff};
   end

   // Sequence one division, loading on start and stepping while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- sv/radix_digit_converter_core.sv -----
// Top level of the radix digit converter: sequencer, digit store and output beat.
//
// Converts one unsigned VALUE_BITS-wide value per request beat into ASCII digits in the
// base held in the csr register (2..36; 0..1 act as 2, 37..63 act as 36; reset 10), and
// sends one response beat per digit, most significant first, with last set on the final
// one. A zero value gives a single '0'. Each digit comes from one division in the shared
// bit-serial divider, and each character passes through the registered read of the digit
// store (ST_READ, then ST_SHOW), so a request takes longer with more digits, and longer
// still if the response side stalls. At most DIGIT_SLOTS digits are kept; with a larger
// value only the least significant DIGIT_SLOTS are sent. The request side is not ready
// until the last response beat of the current value has been taken.
module radix_digit_converter_core #(
   parameter int VALUE_BITS  = 20,
   parameter int DIGIT_SLOTS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   rdc_req_if.sink                     req_chan,
   rdc_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [rdc_pkg::RADIX_W-1:0] csr_wr_data
);
   import rdc_pkg::*;

   localparam int IDX_W = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;

   rdc_state_type         state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;

   logic [DIGIT_W-1:0]    store_mem [DIGIT_SLOTS];
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [DIGIT_W-1:0]    mem_wr_data;

   logic                  req_beat;
   logic                  rsp_beat;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_W-1:0]    div_remainder;
   logic                  conv_end;

   // Shared divider
   rdc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (effective_radix(radix_ff)),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Handshake qualifiers
   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   // Stop dividing once the quotient runs out or the store is full
   assign conv_end = (div_quotient == '0) || (wr_idx_ff == IDX_W'(DIGIT_SLOTS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = (req_chan.value == '0) ? ST_READ : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done && conv_end) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_beat) begin
               state_in = (rd_idx_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      div_start      = 1'b0;
      div_dividend   = div_quotient;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = wr_idx_ff;
      mem_wr_data    = div_remainder;
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            div_dividend   = req_chan.value;
            wr_idx_in      = '0;
            if (req_beat) begin
               if (req_chan.value == '0) begin
                  // Zero gives a single '0' digit
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = '0;
                  mem_wr_data = '0;
                  rd_idx_in   = '0;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mem_wr_en = 1'b1;
               if (conv_end) begin
                  rd_idx_in = wr_idx_ff;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
                  div_start = 1'b1;
               end
            end
         end
         ST_READ: begin
         end
         ST_SHOW: begin
            rsp_chan.valid = 1'b1;
            if (rsp_beat && (rd_idx_ff != '0)) begin
               rd_idx_in = rd_idx_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Response payload from the registered store read
   assign rsp_chan.digit_char = digit_to_ascii(rd_data_ff);
   assign rsp_chan.last       = (rd_idx_ff == '0);

   // Capture the radix register on a write
   always_comb begin
      radix_in = csr_wr_en ? csr_wr_data : radix_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         radix_ff  <= RADIX_RESET;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         radix_ff  <= radix_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // Digit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         store_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

endmodule

// ----- dv/radix_digit_converter_core_tb.sv -----
// Self-checking testbench for the radix digit converter core.
module radix_digit_converter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdc_pkg::*;

   localparam int VALUE_BITS  = 20;
   localparam int DIGIT_SLOTS = 20;
   localparam int CYCLE_LIMIT = 800000;
   localparam int PHASE_ITEMS = 25;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } char_beat_type;

   // Predict the character beats of each value and check them as they leave
   class char_scoreboard_type;
      logic [RADIX_W-1:0] radix_reg;
      char_beat_type      expected_chars[$];
      int unsigned        fail_count;

      function new();
         radix_reg  = RADIX_RESET;
         fail_count = 0;
      endfunction

      function void set_radix(input logic [RADIX_W-1:0] r);
         radix_reg = r;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // Divide repeatedly, keep remainders least significant first, queue them reversed
      function void note_value(input value_type v);
         logic [RADIX_W-1:0] base;
         value_type          rest;
         logic [DIGIT_W-1:0] digits[$];
         char_beat_type      beat;
         int                 k;
         if (radix_reg < RADIX_MIN) begin
            base = RADIX_MIN;
         end else if (radix_reg > RADIX_MAX) begin
            base = RADIX_MAX;
         end else begin
            base = radix_reg;
         end
         rest = v;
         if (rest == '0) begin
            digits.push_back('0);
         end
         while (rest != '0 && digits.size() < DIGIT_SLOTS) begin
            digits.push_back(DIGIT_W'(rest % VALUE_BITS'(base)));
            rest = rest / VALUE_BITS'(base);
         end
         for (k = digits.size() - 1; k >= 0; k--) begin
            if (digits[k] < DECIMAL_LIMIT) begin
               beat.digit_char = CHAR_W'(digits[k]) + ASCII_ZERO;
            end else begin
               beat.digit_char = CHAR_W'(digits[k]) + ASCII_LETTER_BIAS;
            end
            beat.last = (k == 0);
            expected_chars.push_back(beat);
         end
      endfunction

      function void check_char(input logic [CHAR_W-1:0] c, input logic l);
         char_beat_type want;
         if (expected_chars.size() == 0) begin
            $error("character beat 0x%02h last=%0b with nothing expected", c, l);
            fail_count++;
            return;
         end
         want = expected_chars.pop_front();
         if (c !== want.digit_char) begin
            $error("digit_char: expected 0x%02h, actual 0x%02h", want.digit_char, c);
            fail_count++;
         end
         if (l !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, l);
            fail_count++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [RADIX_W-1:0] csr_wr_data;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int unsigned        cycle_count;

   rdc_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus();
   rdc_rsp_if                            rsp_bus();

   char_scoreboard_type sb = new();

   radix_digit_converter_core #(
      .VALUE_BITS  (VALUE_BITS),
      .DIGIT_SLOTS (DIGIT_SLOTS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Check every accepted character beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_char(rsp_bus.digit_char, rsp_bus.last);
      end
   end

   // Give up once the cycle budget is spent
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one value, with an optional random gap first; entered and left at a falling edge
   task automatic send_value(input value_type v);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= value_type'($urandom);
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_value(v);
      @(negedge clock);
   endtask

   // Drop valid, drain the converter, then write the radix
   task automatic write_radix(input logic [RADIX_W-1:0] r);
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(negedge clock);
      sb.set_radix(r);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= RADIX_W'($urandom);
   endtask

   // Mix of small, near-full, full-width and random-width values
   function automatic value_type pick_value();
      value_type mask;
      mask = value_type'((64'd1 << $urandom_range(1, VALUE_BITS)) - 1);
      case ($urandom_range(0, 7))
         0:       return value_type'($urandom_range(0, 40));
         1:       return '1 - value_type'($urandom_range(0, 3));
         2, 3:    return value_type'($urandom);
         default: return value_type'($urandom) & mask;
      endcase
   endfunction

   initial begin
      logic [RADIX_W-1:0] phase_radix[8];
      int                 p;
      int                 i;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset radix, binary at full length, letters, clamped radix values
      send_value('0);
      send_value(value_type'(1));
      send_value(value_type'(9));
      send_value(value_type'(10));
      send_value('1);
      send_value(value_type'(12345));
      write_radix(RADIX_W'(2));
      send_value('0);
      send_value(value_type'(1));
      send_value('1);
      send_value(value_type'(20'h80000));
      send_value(value_type'(20'h55555));
      write_radix(RADIX_W'(36));
      send_value(value_type'(35));
      send_value(value_type'(36));
      send_value('1);
      send_value('0);
      write_radix(RADIX_W'(0));
      send_value(value_type'(5));
      write_radix(RADIX_W'(1));
      send_value('1);
      write_radix(RADIX_W'(37));
      send_value('1);
      write_radix(RADIX_W'(63));
      send_value(value_type'(1295));
      send_value(value_type'(20'hAAAAA));
      write_radix(RADIX_W'(16));
      send_value(value_type'(20'hABCDE));

      // Random phases over several radix settings and idling modes
      phase_radix[0] = RADIX_W'(2);
      phase_radix[1] = RADIX_W'(36);
      phase_radix[2] = RADIX_W'(10);
      phase_radix[3] = RADIX_W'(16);
      phase_radix[4] = RADIX_W'(0);
      phase_radix[5] = RADIX_W'(63);
      phase_radix[6] = RADIX_W'($urandom_range(2, 36));
      phase_radix[7] = RADIX_W'($urandom);
      for (p = 0; p < 8; p++) begin
         write_radix(phase_radix[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_value(pick_value());
         end
      end

      // Drain and let the block settle before the verdict
      req_bus.valid <= 1'b0;
      recv_stall_pct = 0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- radix_digit_converter_core.f -----
sv/rdc_pkg.sv
sv/rdc_if.sv
sv/rdc_divider.sv
sv/radix_digit_converter_core.sv
dv/radix_digit_converter_core_tb.sv
